// ===== sv/u8u16_pkg.sv =====
// Package: constants, result type and code unit helpers for the UTF-8 to UTF-16 transcoder.
`default_nettype none
package u8u16_pkg;

    localparam int unsigned FifoDepth = 4;
    localparam int unsigned PtrW      = $clog2(FifoDepth);
    localparam int unsigned CntW      = $clog2(FifoDepth + 1);

    localparam logic [7:0]  LeadFour   = 8'hF0;
    localparam logic [7:0]  LeadThree  = 8'hE0;
    localparam logic [7:0]  LeadTwo    = 8'hC0;
    localparam logic [7:0]  ContMark   = 8'h80;
    localparam logic [7:0]  ContMask   = 8'h3F;
    localparam logic [20:0] AsciiMax   = 21'd127;
    localparam logic [20:0] BmpMax     = 21'h00FFFF;
    localparam logic [20:0] SuppBase   = 21'h010000;
    localparam logic [15:0] HiSurr     = 16'hD800;
    localparam logic [15:0] LoSurr     = 16'hDC00;

    // sequence length codes (length minus one)
    typedef enum logic [1:0] {
        SEQ_ONE   = 2'd0,
        SEQ_TWO   = 2'd1,
        SEQ_THREE = 2'd2,
        SEQ_FOUR  = 2'd3
    } t_seq;

    // one output word
    typedef struct packed {
        logic        bad_input;
        logic        end_mark;
        logic [15:0] code_unit;
    } t_res;

    localparam t_res ResBad = '{bad_input: 1'b1, end_mark: 1'b0, code_unit: 16'h0000};
    localparam t_res ResEnd = '{bad_input: 1'b0, end_mark: 1'b1, code_unit: 16'h0000};

    function automatic t_res unit_word(input logic [15:0] unit);
        t_res r;
        r.bad_input = 1'b0;
        r.end_mark  = 1'b0;
        r.code_unit = unit;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/utf8_to_utf16_transcoder.sv =====
// Top level: UTF-8 byte stream in, UTF-16 code unit stream out.
//
// Usage:
//   Slave stream s_axis_* takes one UTF-8 byte per word in tdata. A zero
//   byte ends a string. Master stream m_axis_* gives one UTF-16 code unit
//   per word in tdata; tlast marks the terminating zero unit and tuser
//   flags an error word (malformed input), after which bytes are dropped
//   up to and including the next zero byte.
//   A result is written into a four-word output queue on the accepting
//   edge and is read out of the queue onto m_axis in order.
//   Throughput: one byte per cycle while s_axis_tready is high. A byte
//   gives zero, one or two words; a code point above 0xFFFF gives a
//   surrogate pair from its last byte. The output side moves one word per
//   cycle, so the queue absorbs pairs. s_axis_tready is high while the
//   queue has room for two words, so a stalled receiver backs the input
//   up after the queue fills; no word is lost. Synchronous active-low
//   reset clears the decoder state and empties the queue.
`default_nettype none
module utf8_to_utf16_transcoder
    import u8u16_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input byte stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    // output code unit stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] code_unit
    output logic             m_axis_tlast,   // end_mark
    output logic             m_axis_tuser    // [0] bad_input
);

    // decoder state
    logic [1:0]  r_pending, n_pending;
    logic [20:0] r_accum,   n_accum;
    t_seq        r_seq,     n_seq;
    logic        r_discard, n_discard;

    // output queue
    t_res            r_fifo [FifoDepth];
    logic [PtrW-1:0] r_wptr, r_rptr;
    logic [CntW-1:0] r_cnt;

    logic        in_acc, out_acc;
    logic [7:0]  b;
    logic [1:0]  nres;
    logic        emit;
    t_res        res0, res1;
    logic [20:0] cp, shifted, supp;

    assign b       = s_axis_tdata;
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_cnt <= CntW'(FifoDepth - 2));

    assign shifted = {r_accum[14:0], b[5:0] & ContMask[5:0]};

    // decode one byte
    always_comb begin
        n_pending = r_pending;
        n_accum   = r_accum;
        n_seq     = r_seq;
        n_discard = r_discard;
        nres      = 2'd0;
        emit      = 1'b0;
        res0      = ResBad;
        res1      = ResBad;
        cp        = 21'd0;
        if (r_discard) begin
            if (b == 8'h00) begin
                n_discard = 1'b0;
            end
        end else if (r_pending != 2'd0) begin
            if ((b & ContMark) != ContMark) begin
                n_pending = 2'd0;
                n_accum   = 21'd0;
                n_seq     = SEQ_ONE;
                n_discard = (b != 8'h00);
                nres      = 2'd1;
                res0      = ResBad;
            end else if (r_pending != 2'd1) begin
                n_accum   = shifted;
                n_pending = r_pending - 2'd1;
            end else begin
                cp        = shifted;
                n_pending = 2'd0;
                n_accum   = 21'd0;
                n_seq     = SEQ_ONE;
                if (r_seq == SEQ_TWO && cp <= AsciiMax) begin
                    n_discard = 1'b1;
                    nres      = 2'd1;
                    res0      = ResBad;
                end else begin
                    nres = 2'd1;
                    emit = 1'b1;
                end
            end
        end else begin
            priority if (b == 8'h00) begin
                nres = 2'd1;
                res0 = ResEnd;
            end else if ((b & LeadFour) == LeadFour) begin
                n_accum   = {18'd0, b[2:0]};
                n_seq     = SEQ_FOUR;
                n_pending = 2'd3;
            end else if ((b & LeadThree) == LeadThree) begin
                n_accum   = {17'd0, b[3:0]};
                n_seq     = SEQ_THREE;
                n_pending = 2'd2;
            end else if ((b & LeadTwo) == LeadTwo) begin
                n_accum   = {16'd0, b[4:0]};
                n_seq     = SEQ_TWO;
                n_pending = 2'd1;
            end else if (b[7] == 1'b0) begin
                cp   = {13'd0, b};
                nres = 2'd1;
                emit = 1'b1;
            end else begin
                n_discard = 1'b1;
                nres      = 2'd1;
                res0      = ResBad;
            end
        end
        // a finished code point: one unit or a surrogate pair
        supp = cp - SuppBase;
        if (emit) begin
            if (cp > BmpMax) begin
                nres = 2'd2;
                res0 = unit_word(HiSurr + {5'd0, supp[20:10]});
                res1 = unit_word(LoSurr + {6'd0, supp[9:0]});
            end else begin
                res0 = unit_word(cp[15:0]);
            end
        end
    end

    // decoder state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_accum   <= 21'd0;
            r_seq     <= SEQ_ONE;
            r_discard <= 1'b0;
        end else if (in_acc) begin
            r_pending <= n_pending;
            r_accum   <= n_accum;
            r_seq     <= n_seq;
            r_discard <= n_discard;
        end
    end

    // queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (in_acc) begin
                r_wptr <= r_wptr + PtrW'(nres);
            end
            if (out_acc) begin
                r_rptr <= r_rptr + PtrW'(1);
            end
            r_cnt <= r_cnt + (in_acc ? CntW'(nres) : CntW'(0))
                           - (out_acc ? CntW'(1) : CntW'(0));
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (in_acc && nres != 2'd0) begin
            r_fifo[r_wptr] <= res0;
        end
        if (in_acc && nres == 2'd2) begin
            r_fifo[r_wptr + PtrW'(1)] <= res1;
        end
    end

    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = r_fifo[r_rptr].code_unit;
    assign m_axis_tlast  = r_fifo[r_rptr].end_mark;
    assign m_axis_tuser  = r_fifo[r_rptr].bad_input;

    // checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(FifoDepth))
        else $error("output queue overflow");

    a_pend_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= r_seq)
        else $error("pending count exceeds sequence length");

    a_disc_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_discard |-> (r_pending == 2'd0))
        else $error("discarding while a sequence is open");

    a_valid_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |=> !($past(out_acc)))
        else $error("word taken from empty queue");

endmodule
`default_nettype wire
